[rtl/ufrc_pkg.sv]
// Shared types, constants and helper functions for the UART frame receiver.
// No dependencies; used by uart_frame_receiver_crc16_top.
package ufrc_pkg;

   localparam int BUF_BYTES       = 1024;
   localparam int HEADER_BYTES    = 8;
   localparam int CRC_TRAIL_BYTES = 2;
   localparam int HDR_IDX_W       = $clog2(HEADER_BYTES);
   localparam int IDX_W           = $clog2(BUF_BYTES) + 1;
   localparam int LEN_W           = 17;
   localparam int CSR_IDX_W       = 3;
   localparam int CSR_DATA_W      = 16;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;

   localparam logic [7:0]  START_BYTE_RST   = 8'd170;
   localparam logic [9:0]  MAX_PAYLOAD_RST  = 10'd1014;
   localparam logic [15:0] LINK_TIMEOUT_RST = 16'd2000;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_START_BYTE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_PAYLOAD  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LINK_TIMEOUT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CMD_TYPE_A   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CMD_TYPE_B   = 3'd4;

   typedef enum logic [1:0] {
      PH_HUNT   = 2'd0,
      PH_HEADER = 2'd1,
      PH_BODY   = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      EV_NONE     = 3'd0,
      EV_DATA     = 3'd1,
      EV_GOOD     = 3'd2,
      EV_BAD      = 3'd3,
      EV_OVERFLOW = 3'd4,
      EV_LINKDOWN = 3'd5
   } event_type;

   typedef struct packed {
      logic       cmd;
      logic [7:0] rx_byte;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]  event_res;
      logic [7:0]  data_byte;
      logic [7:0]  frame_type;
      logic [7:0]  sequence_res;
      logic [15:0] payload_length;
      logic [31:0] sent_time;
      logic        link_up;
      logic        is_command;
      logic [15:0] good_frames;
      logic [15:0] bad_frames;
      logic [15:0] overflow_frames;
   } rsp_payload_type;

   // CRC-16/CCITT-FALSE, one byte, MSB first
   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

   function automatic logic [15:0] sat_inc(input logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

endpackage

[rtl/uart_frame_receiver_crc16_top.sv]
// UART frame receiver: start-byte hunt, 8-byte header, payload, CRC-16 check,
// link supervision. Depends on ufrc_pkg.
//
// Usage:
//   req channel: one request per received UART byte (cmd = 0) or per
//   millisecond tick (cmd = 1). Every request yields exactly one response.
//   rsp channel: event code, payload byte on a data event, the header fields
//   as currently held, link state and the three saturating frame counters.
//   csr port: write-only; csr_index selects start byte, max payload, link
//   timeout, command type A, command type B. Write only while idle.
// Response: registered, valid in the cycle after a request is accepted.
// Throughput: one request per cycle while req_stall is low; the whole step (bytewise
//   CRC over one byte, header capture, length compare) sits between the request
//   handshake and the response register.
// Reset: synchronous; hunts for the start byte, link down, counters zero,
//   header fields zero, registers at their defaults.
// Stall: the response register holds while rsp_stall is high; req_stall is
//   raised only when that register is full and stalled, so a new request is
//   taken in the same cycle the old response leaves.
module uart_frame_receiver_crc16_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  ufrc_pkg::req_payload_type           req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output ufrc_pkg::rsp_payload_type           rsp_payload,
   input  logic                                csr_write,
   input  logic [ufrc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ufrc_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import ufrc_pkg::*;

   // configuration
   logic [7:0]  start_byte_ff;
   logic [9:0]  max_payload_ff;
   logic [15:0] link_timeout_ff;
   logic [7:0]  cmd_type_a_ff;
   logic [7:0]  cmd_type_b_ff;

   // frame state
   phase_type                         phase_ff, phase_in;
   logic [IDX_W-1:0]                  byte_index_ff, byte_index_in;
   logic [15:0]                       crc_ff, crc_in;
   logic [HEADER_BYTES-1:0][7:0]      hdr_ff, hdr_in;
   logic [7:0]                        crc_high_ff, crc_high_in;
   logic                              link_ff, link_in;
   logic [15:0]                       quiet_ff, quiet_in;
   logic [15:0]                       good_ff, good_in;
   logic [15:0]                       bad_ff, bad_in;
   logic [15:0]                       ovf_ff, ovf_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   rsp_payload_type                   rsp_payload_ff, rsp_payload_in;

   logic                              accept;
   logic                              is_byte;
   logic [7:0]                        b;
   logic                              start_hit;
   logic                              hdr_done;
   logic [LEN_W-1:0]                  new_frame_len;
   logic                              too_big;
   logic [15:0]                       plen;
   logic [LEN_W-1:0]                  crc_pos;
   logic [LEN_W-1:0]                  idx_ext;
   logic                              in_payload;
   logic                              at_crc_high;
   logic                              frame_end;
   event_type                         ev;
   logic [7:0]                        data_out;
   logic                              is_cmd;

   assign req_stall   = rsp_valid_ff & rsp_stall;
   assign accept      = req_valid & ~req_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   assign is_byte = ~req_payload.cmd;
   assign b       = req_payload.rx_byte;

   // header capture; header bytes arrive in order 0..7
   always_comb begin
      hdr_in = hdr_ff;
      if (is_byte && phase_ff == PH_HEADER) begin
         hdr_in[byte_index_ff[HDR_IDX_W-1:0]] = b;
      end
   end

   // frame condition flags
   always_comb begin
      start_hit     = (b == start_byte_ff);
      hdr_done      = (byte_index_ff + IDX_W'(1)) >= IDX_W'(HEADER_BYTES);
      new_frame_len = LEN_W'(HEADER_BYTES) + LEN_W'({hdr_in[7], hdr_in[6]})
                      + LEN_W'(CRC_TRAIL_BYTES);
      too_big       = new_frame_len > LEN_W'(BUF_BYTES);
      plen          = {hdr_ff[7], hdr_ff[6]};
      crc_pos       = LEN_W'(HEADER_BYTES) + LEN_W'(plen);
      idx_ext       = LEN_W'(byte_index_ff);
      in_payload    = idx_ext < crc_pos;
      at_crc_high   = idx_ext == crc_pos;
      frame_end     = !in_payload && !at_crc_high;
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (is_byte) begin
         unique case (phase_ff)
            PH_HUNT: begin
               if (start_hit) phase_in = PH_HEADER;
            end
            PH_HEADER: begin
               if (hdr_done) phase_in = too_big ? PH_HUNT : PH_BODY;
            end
            PH_BODY: begin
               if (frame_end) phase_in = PH_HUNT;
            end
            default: phase_in = PH_HUNT;
         endcase
      end
   end

   // datapath and response
   always_comb begin
      byte_index_in = byte_index_ff;
      crc_in        = crc_ff;
      crc_high_in   = crc_high_ff;
      link_in       = link_ff;
      quiet_in      = quiet_ff;
      good_in       = good_ff;
      bad_in        = bad_ff;
      ovf_in        = ovf_ff;
      ev            = EV_NONE;
      data_out      = 8'd0;
      is_cmd        = 1'b0;

      if (!is_byte) begin
         // tick: only the link timer moves
         if (link_ff) begin
            if (quiet_ff >= link_timeout_ff) begin
               link_in  = 1'b0;
               quiet_in = 16'd0;
               ev       = EV_LINKDOWN;
            end else begin
               quiet_in = sat_inc(quiet_ff);
            end
         end
      end else begin
         unique case (phase_ff)
            PH_HUNT: begin
               if (start_hit) begin
                  byte_index_in = '0;
                  crc_in        = CRC_INIT;
               end
            end
            PH_HEADER: begin
               crc_in        = crc_feed(crc_ff, b);
               byte_index_in = byte_index_ff + IDX_W'(1);
               if (hdr_done && too_big) begin
                  ovf_in = sat_inc(ovf_ff);
                  ev     = EV_OVERFLOW;
               end
            end
            PH_BODY: begin
               if (in_payload) begin
                  crc_in        = crc_feed(crc_ff, b);
                  ev            = EV_DATA;
                  data_out      = b;
                  byte_index_in = byte_index_ff + IDX_W'(1);
               end else if (at_crc_high) begin
                  crc_high_in   = b;
                  byte_index_in = byte_index_ff + IDX_W'(1);
               end else begin
                  if (plen <= 16'(max_payload_ff) && {crc_high_ff, b} == crc_ff) begin
                     good_in  = sat_inc(good_ff);
                     link_in  = 1'b1;
                     quiet_in = 16'd0;
                     ev       = EV_GOOD;
                     is_cmd   = (hdr_ff[0] == cmd_type_a_ff) || (hdr_ff[0] == cmd_type_b_ff);
                  end else begin
                     bad_in = sat_inc(bad_ff);
                     ev     = EV_BAD;
                  end
                  byte_index_in = '0;
               end
            end
            default: ;
         endcase
      end

      rsp_payload_in.event_res       = ev;
      rsp_payload_in.data_byte       = data_out;
      rsp_payload_in.frame_type      = hdr_in[0];
      rsp_payload_in.sequence_res    = hdr_in[1];
      rsp_payload_in.payload_length  = {hdr_in[7], hdr_in[6]};
      rsp_payload_in.sent_time       = {hdr_in[5], hdr_in[4], hdr_in[3], hdr_in[2]};
      rsp_payload_in.link_up         = link_in;
      rsp_payload_in.is_command      = is_cmd;
      rsp_payload_in.good_frames     = good_in;
      rsp_payload_in.bad_frames      = bad_in;
      rsp_payload_in.overflow_frames = ovf_in;
   end

   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff   <= START_BYTE_RST;
         max_payload_ff  <= MAX_PAYLOAD_RST;
         link_timeout_ff <= LINK_TIMEOUT_RST;
         cmd_type_a_ff   <= 8'd0;
         cmd_type_b_ff   <= 8'd0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_START_BYTE:   start_byte_ff   <= csr_wdata[7:0];
            CSR_MAX_PAYLOAD:  max_payload_ff  <= csr_wdata[9:0];
            CSR_LINK_TIMEOUT: link_timeout_ff <= csr_wdata[15:0];
            CSR_CMD_TYPE_A:   cmd_type_a_ff   <= csr_wdata[7:0];
            CSR_CMD_TYPE_B:   cmd_type_b_ff   <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // frame state, advanced once per accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HUNT;
         byte_index_ff <= '0;
         crc_ff        <= CRC_INIT;
         hdr_ff        <= '0;
         crc_high_ff   <= 8'd0;
         link_ff       <= 1'b0;
         quiet_ff      <= 16'd0;
         good_ff       <= 16'd0;
         bad_ff        <= 16'd0;
         ovf_ff        <= 16'd0;
      end else if (accept) begin
         phase_ff      <= phase_in;
         byte_index_ff <= byte_index_in;
         crc_ff        <= crc_in;
         hdr_ff        <= hdr_in;
         crc_high_ff   <= crc_high_in;
         link_ff       <= link_in;
         quiet_ff      <= quiet_in;
         good_ff       <= good_in;
         bad_ff        <= bad_in;
         ovf_ff        <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   // checks
   a_rsp_after_req: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("no response after accepted request");

   a_cmd_only_good: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_payload_ff.is_command |-> rsp_payload_ff.event_res == EV_GOOD)
      else $error("command flag without good frame");

   a_linkdown_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_payload_ff.event_res == EV_LINKDOWN |-> !rsp_payload_ff.link_up)
      else $error("link-down event with link still up");

   a_good_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> good_ff >= $past(good_ff))
      else $error("good frame counter went down");

   a_body_past_header: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_BODY |-> byte_index_ff >= IDX_W'(HEADER_BYTES))
      else $error("payload phase before header complete");

endmodule
